@@ hdl/wios_pkg.sv @@
// Shared types and constants for the weighted interval overlap sum block.
// No dependencies; used by every module under hdl/.
package wios_pkg;

	localparam int MAX_INTERVALS = 64;
	localparam int IDX_W  = $clog2(MAX_INTERVALS);
	localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
	localparam int TIME_W = 32;
	localparam int CORE_W = 6;
	localparam int WGT_W  = CORE_W + 1;
	localparam int TERM_W = TIME_W + WGT_W;
	localparam int ACC_W  = 50;
	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// one stored interval
	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] dur;
		logic [CORE_W-1:0] cores;
	} interval_t;

	// what every cell of the ring does this cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_ROTATE,
		CELL_INSERT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INSERT,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	// controls from the sequencer to the datapath
	typedef struct packed {
		cell_op_t chain_op;
		logic     cmp_valid;
		logic     load_item;
		logic     emit;
		logic     overflow;
	} ctrl_t;

endpackage

@@ hdl/weighted_interval_overlap_sum_top.sv @@
// Weighted interval overlap sum: top level.
// Each stored interval is accepted, then scanned, inserted and flushed with the input
// stalled; the scan is set by the 64-cell ring rotating past the single overlap unit.
// A dropped one is only accepted. After the last beat, emit loads the output register;
// the input stays stalled through emit, and longer while a result is stalled.
// Reset clears control, counts and the accumulator; cell contents are left as they are.
module weighted_interval_overlap_sum_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [wios_pkg::TIME_W-1:0]       start_time,
	input  logic [wios_pkg::TIME_W-1:0]       duration,
	input  logic [wios_pkg::CORE_W-1:0]       cores_needed,
	input  logic                              last_interval,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [wios_pkg::ACC_W-1:0]        total_overlap,
	output logic                              overflow_flag
);

	wios_pkg::ctrl_t             ctl;
	wios_pkg::interval_t         item_q, head;
	logic [wios_pkg::ACC_W-1:0]  acc;
	logic                        out_valid_q, overflow_q;
	logic [wios_pkg::ACC_W-1:0]  total_q;
	logic                        out_busy;

	assign out_busy = out_valid_q && out_stall;

	wios_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (last_interval),
		.out_busy (out_busy),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	// incoming interval, held for the whole scan
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			item_q.start <= start_time;
			item_q.dur   <= duration;
			item_q.cores <= cores_needed;
		end
	end

	wios_chain u_chain (
		.clk      (clk),
		.op       (ctl.chain_op),
		.new_item (item_q),
		.head     (head)
	);

	wios_ovl_unit u_ovl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (ctl.cmp_valid),
		.a      (head),
		.b      (item_q),
		.clear  (ctl.emit),
		.acc    (acc)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			total_q    <= acc;
			overflow_q <= ctl.overflow;
		end
	end

	assign out_valid     = out_valid_q;
	assign total_overlap = total_q;
	assign overflow_flag = overflow_q;

endmodule

@@ hdl/wios_cell.sv @@
// One cell of the interval ring: holds a single stored interval.
// Depends on wios_pkg.
module wios_cell (
	input  logic                clk,
	input  wios_pkg::cell_op_t  op,
	input  wios_pkg::interval_t rot_in,
	input  wios_pkg::interval_t ins_in,
	output wios_pkg::interval_t data
);

	wios_pkg::interval_t data_q;

	// rotate toward the head, or shift toward the tail on insert
	always_ff @(posedge clk) begin
		case (op)
			wios_pkg::CELL_ROTATE: data_q <= rot_in;
			wios_pkg::CELL_INSERT: data_q <= ins_in;
			default:               data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

@@ hdl/wios_chain.sv @@
// Ring of interval cells; cell 0 is the head seen by the overlap unit.
// Depends on wios_pkg and wios_cell.
module wios_chain (
	input  logic                clk,
	input  wios_pkg::cell_op_t  op,
	input  wios_pkg::interval_t new_item,
	output wios_pkg::interval_t head
);

	wios_pkg::interval_t cell_data [wios_pkg::MAX_INTERVALS];

	// rotate: cell i takes cell i+1, the tail takes the head
	// insert: cell i takes cell i-1, the head takes the new interval
	for (genvar i = 0; i < wios_pkg::MAX_INTERVALS; i++) begin : g_cell
		wios_cell u_cell (
			.clk    (clk),
			.op     (op),
			.rot_in (cell_data[(i + 1) % wios_pkg::MAX_INTERVALS]),
			.ins_in ((i == 0) ? new_item : cell_data[(i + wios_pkg::MAX_INTERVALS - 1)
				% wios_pkg::MAX_INTERVALS]),
			.data   (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

@@ hdl/wios_ovl_unit.sv @@
// Shared overlap unit: overlap and weight, multiply, saturating accumulate.
// Depends on wios_pkg.
module wios_ovl_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_vld,
	input  wios_pkg::interval_t               a,
	input  wios_pkg::interval_t               b,
	input  logic                              clear,
	output logic [wios_pkg::ACC_W-1:0]        acc
);

	localparam int EW = wios_pkg::TIME_W + 1;

	logic [EW-1:0]                   end_a, end_b, hi, lo;
	logic [wios_pkg::TIME_W-1:0]     ovl;
	logic [EW-1:0]                   diff;
	logic [wios_pkg::WGT_W-1:0]      csum, wgt;
	logic [wios_pkg::TIME_W-1:0]     ovl_s1;
	logic [wios_pkg::WGT_W-1:0]      wgt_s1;
	logic                            vld_s1, vld_s2;
	logic [wios_pkg::TERM_W-1:0]     term_s2;
	logic [wios_pkg::ACC_W:0]        sum;
	logic [wios_pkg::ACC_W-1:0]      acc_q;

	// stage 1: overlap length and weight
	always_comb begin
		end_a = {1'b0, a.start} + {1'b0, a.dur};
		end_b = {1'b0, b.start} + {1'b0, b.dur};
		lo    = (a.start > b.start) ? {1'b0, a.start} : {1'b0, b.start};
		hi    = (end_a < end_b) ? end_a : end_b;
		diff  = hi - lo;
		// overlap never exceeds either duration, so 32 bits hold it
		ovl   = (hi > lo) ? diff[wios_pkg::TIME_W-1:0] : '0;
		csum  = {1'b0, a.cores} + {1'b0, b.cores};
		wgt   = (csum > wios_pkg::WGT_W'(1)) ? csum - wios_pkg::WGT_W'(1) : '0;
	end

	always_ff @(posedge clk) begin
		ovl_s1  <= ovl;
		wgt_s1  <= wgt;
		term_s2 <= wios_pkg::TERM_W'(ovl_s1) * wios_pkg::TERM_W'(wgt_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 3: saturating accumulate
	assign sum = {1'b0, acc_q} + (wios_pkg::ACC_W + 1)'(term_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= (sum >= {1'b0, wios_pkg::ACC_MAX}) ? wios_pkg::ACC_MAX
				: sum[wios_pkg::ACC_W-1:0];
		end
	end

	assign acc = acc_q;

endmodule

@@ hdl/wios_ctrl.sv @@
// Sequencer: accepts beats, steps the ring scan, counts stored intervals.
// Depends on wios_pkg.
module wios_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	input  logic            out_busy,
	output logic            in_stall,
	output wios_pkg::ctrl_t ctl
);

	wios_pkg::state_t            state_q, state_d;
	logic [wios_pkg::IDX_W-1:0]  step_q;
	logic [wios_pkg::CNT_W-1:0]  count_q;
	logic                        dropped_q, last_q;
	logic                        full, last_step;

	assign full      = (count_q == wios_pkg::CNT_W'(wios_pkg::MAX_INTERVALS));
	assign last_step = (step_q == wios_pkg::IDX_W'(wios_pkg::MAX_INTERVALS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wios_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (full) begin
						state_d = in_last ? wios_pkg::ST_EMIT : wios_pkg::ST_IDLE;
					end else begin
						state_d = wios_pkg::ST_SCAN;
					end
				end
			end
			wios_pkg::ST_SCAN: begin
				if (last_step) state_d = wios_pkg::ST_INSERT;
			end
			wios_pkg::ST_INSERT: state_d = wios_pkg::ST_FLUSH;
			wios_pkg::ST_FLUSH: begin
				state_d = last_q ? wios_pkg::ST_EMIT : wios_pkg::ST_IDLE;
			end
			wios_pkg::ST_EMIT: begin
				if (!out_busy) state_d = wios_pkg::ST_IDLE;
			end
			default: state_d = wios_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall      = 1'b1;
		ctl.chain_op  = wios_pkg::CELL_HOLD;
		ctl.cmp_valid = 1'b0;
		ctl.load_item = 1'b0;
		ctl.emit      = 1'b0;
		ctl.overflow  = dropped_q;
		case (state_q)
			wios_pkg::ST_IDLE: begin
				in_stall      = 1'b0;
				ctl.load_item = in_valid;
			end
			wios_pkg::ST_SCAN: begin
				ctl.chain_op  = wios_pkg::CELL_ROTATE;
				ctl.cmp_valid = (wios_pkg::CNT_W'(step_q) < count_q);
			end
			wios_pkg::ST_INSERT: ctl.chain_op = wios_pkg::CELL_INSERT;
			wios_pkg::ST_EMIT:   ctl.emit = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wios_pkg::ST_IDLE;
			step_q    <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_item) begin
				step_q <= '0;
				last_q <= in_last;
				if (full) dropped_q <= 1'b1;
			end else if (state_q == wios_pkg::ST_SCAN) begin
				step_q <= step_q + wios_pkg::IDX_W'(1);
			end
			if (state_q == wios_pkg::ST_INSERT) begin
				count_q <= count_q + wios_pkg::CNT_W'(1);
			end
			// end of set
			if (ctl.emit) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

endmodule
